### hdl/ppst_pkg.sv
`default_nettype none
package ppst_pkg;

	localparam int unsigned MaxWaypointsDef = 1024;
	localparam int unsigned SlotW = 10;
	localparam int unsigned CfgDataW = 23;
	localparam int unsigned CfgIdxW = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_POSE = 1'b1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_COUNT        = 3'd0,
		REG_HORIZON      = 3'd1,
		REG_STEER_LIM    = 3'd2,
		REG_TOP_SPEED    = 3'd3,
		REG_BOTTOM_SPEED = 3'd4
	} cfg_reg_t;

	localparam logic [10:0] CountRst   = 11'd0;
	localparam logic [22:0] HorizonRst = 23'd65536;
	localparam logic [13:0] LimRst     = 14'd2949;
	localparam logic [15:0] TopRst     = 16'd768;
	localparam logic [15:0] BottomRst  = 16'd128;

	typedef struct packed {
		logic               operation;
		logic [9:0]         slot;
		logic signed [31:0] waypoint_east;
		logic signed [31:0] waypoint_north;
		logic signed [31:0] pose_east;
		logic signed [31:0] pose_north;
		logic signed [15:0] quat_i;
		logic signed [15:0] quat_j;
		logic signed [15:0] quat_k;
		logic signed [15:0] quat_real;
	} req_t;

	typedef struct packed {
		logic signed [11:0] steer_angle;
		logic [15:0]        drive_speed;
		logic [9:0]         goal_slot;
		logic               goal_found;
	} rsp_t;

	typedef struct packed {
		logic               found;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic [63:0]        d2;
	} goal_t;

	typedef struct packed {
		logic signed [15:0] qi;
		logic signed [15:0] qj;
		logic signed [15:0] qk;
		logic signed [15:0] qw;
	} quat_t;

	typedef struct packed {
		logic [13:0] lim;
		logic [15:0] top;
		logic [15:0] bottom;
	} speed_cfg_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] rem_init;
		logic [63:0] divisor;
		logic [6:0]  steps;
	} div_req_t;

endpackage
`default_nettype wire

### hdl/ppst_chan.sv
`default_nettype none
interface ppst_chan #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/pure_pursuit_steering.sv
// Pure pursuit steering controller.
// request channel (ppst_chan of req_t): operation selects a waypoint load or a
// pose update. A load writes east/north into its slot and gives no result. A
// pose update scans the waypoint ring from the tracked slot and returns one
// response item (ppst_chan of rsp_t) with steering, speed, tracked slot and
// found flag.
// Pose update: the start slot is first reduced into the active ring by
// subtracting the ring length, then the scan reads one waypoint per cycle from
// the waypoint memory, then the arithmetic sequencer runs the shared radix-2
// divider (up to three uses, two of them 64-step) and a 17-step square root.
// One item is processed at a time.
// Configuration: cfg_wen, cfg_index, cfg_data write one register per cycle.
// Reset restores register defaults and clears the tracked slot; waypoint
// memory contents stay undefined until loaded.
// A finished result waits in the response register while loads continue to
// transfer; the next pose result holds until the response register frees up.
`default_nettype none
module pure_pursuit_steering #(
	parameter int unsigned MAX_WAYPOINTS = ppst_pkg::MaxWaypointsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [ppst_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [ppst_pkg::CfgDataW-1:0]   cfg_data,
	ppst_chan.sink                          request,
	ppst_chan.source                        response
);
	import ppst_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WAYPOINTS);

	typedef enum logic [3:0] {
		TOP_IDLE  = 4'b0001,
		TOP_SCAN  = 4'b0010,
		TOP_STEER = 4'b0100,
		TOP_WAIT  = 4'b1000
	} top_state_t;

	top_state_t state_q;
	logic [10:0] count_q;
	logic [22:0] horizon_q;
	speed_cfg_t spd_q;
	quat_t quat_q;
	logic found_q;
	logic out_valid_q;
	rsp_t out_q;

	logic acc, load_wr, pose_go;
	logic scan_done, steer_done;
	goal_t goal;
	logic [AW-1:0] tracked;
	logic signed [11:0] steer;
	logic [15:0] speed;
	logic out_free;

	assign request.ready = (state_q == TOP_IDLE);
	assign acc = request.valid && request.ready;
	assign load_wr = acc && (request.data.operation == OP_LOAD);
	assign pose_go = acc && (request.data.operation == OP_POSE);
	assign out_free = !out_valid_q || response.ready;

	ppst_scan #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (load_wr),
		.wr_slot    (request.data.slot),
		.wr_east    (request.data.waypoint_east),
		.wr_north   (request.data.waypoint_north),
		.start      (pose_go),
		.pose_east  (request.data.pose_east),
		.pose_north (request.data.pose_north),
		.count      (count_q),
		.horizon    (horizon_q),
		.done       (scan_done),
		.goal       (goal),
		.tracked    (tracked)
	);

	ppst_steer u_steer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_done),
		.goal   (goal),
		.quat   (quat_q),
		.spd    (spd_q),
		.done   (steer_done),
		.steer  (steer),
		.speed  (speed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CountRst;
			horizon_q <= HorizonRst;
			spd_q <= '{lim: LimRst, top: TopRst, bottom: BottomRst};
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COUNT:        count_q <= cfg_data[10:0];
				REG_HORIZON:      horizon_q <= cfg_data;
				REG_STEER_LIM:    spd_q.lim <= cfg_data[13:0];
				REG_TOP_SPEED:    spd_q.top <= cfg_data[15:0];
				REG_BOTTOM_SPEED: spd_q.bottom <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && response.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				TOP_IDLE: begin
					if (pose_go) state_q <= TOP_SCAN;
				end
				TOP_SCAN: begin
					if (scan_done) state_q <= TOP_STEER;
				end
				TOP_STEER: begin
					if (steer_done) state_q <= TOP_WAIT;
				end
				TOP_WAIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= TOP_IDLE;
					end
				end
				default: state_q <= TOP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pose_go) begin
			quat_q <= '{qi: request.data.quat_i, qj: request.data.quat_j,
				qk: request.data.quat_k, qw: request.data.quat_real};
		end
		if (scan_done) found_q <= goal.found;
		if (state_q == TOP_WAIT && out_free) begin
			out_q <= '{steer_angle: steer, drive_speed: speed,
				goal_slot: SlotW'(tracked), goal_found: found_q};
		end
	end

	assign response.valid = out_valid_q;
	assign response.data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n) scan_done |-> state_q == TOP_SCAN)
		else $error("scan finished outside a pose update");
	assert property (@(posedge clk) disable iff (!arst_n) steer_done |-> state_q == TOP_STEER)
		else $error("steering finished outside its phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.steer_angle <= 12'sd1638 && out_q.steer_angle >= -12'sd1638))
		else $error("steering out of clamp range");
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> 32'(tracked) < MAX_WAYPOINTS)
		else $error("tracked slot beyond ring depth");
endmodule
`default_nettype wire

### hdl/ppst_div.sv
`default_nettype none
module ppst_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ppst_pkg::div_req_t  req,
	output logic                done,
	output logic [63:0]         quotient
);
	logic [63:0] x_q, q_q, d_q, rem_q;
	logic [6:0]  cnt_q;
	logic        run_q, done_q;
	logic [64:0] rem_sh, rem_nx;
	logic        ge;

	always_comb begin
		rem_sh = {rem_q, x_q[63]};
		ge = rem_sh >= {1'b0, d_q};
		rem_nx = ge ? rem_sh - {1'b0, d_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.dividend;
			rem_q <= req.rem_init;
			d_q <= req.divisor;
			q_q <= '0;
		end else if (run_q) begin
			x_q <= {x_q[62:0], 1'b0};
			rem_q <= rem_nx[63:0];
			q_q <= {q_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = q_q;
endmodule
`default_nettype wire

### hdl/ppst_scan.sv
`default_nettype none
module ppst_scan #(
	parameter int unsigned MAX_WAYPOINTS = ppst_pkg::MaxWaypointsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ppst_pkg::SlotW-1:0]        wr_slot,
	input  logic signed [31:0]                wr_east,
	input  logic signed [31:0]                wr_north,
	input  logic                              start,
	input  logic signed [31:0]                pose_east,
	input  logic signed [31:0]                pose_north,
	input  logic [10:0]                       count,
	input  logic [22:0]                       horizon,
	output logic                              done,
	output ppst_pkg::goal_t                   goal,
	output logic [$clog2(MAX_WAYPOINTS)-1:0]  tracked
);
	import ppst_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WAYPOINTS);
	localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

	typedef enum logic [2:0] {
		SC_IDLE = 3'b001,
		SC_MOD  = 3'b010,
		SC_RUN  = 3'b100
	} sc_state_t;

	sc_state_t state_q;
	logic [63:0] mem [MAX_WAYPOINTS];
	logic [63:0] rd_s1;
	logic [CW-1:0] n_q, addr_q, issued_q, idx_s1, idx_s2, idx_s3;
	logic signed [31:0] px_q, py_q;
	logic [45:0] h2_q;
	logic [AW-1:0] tracked_q;
	logic v_s1, v_s2, v_s3, done_q;
	logic signed [32:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic [64:0] sqx_s3, sqy_s3;
	goal_t goal_q;

	logic [31:0] n_full;
	logic [CW-1:0] n_w;
	logic issue, hit, drained;
	logic signed [32:0] dx_w, dy_w;
	logic [32:0] mx, my;
	logic [65:0] sqx, sqy, sum;
	logic [63:0] d2sat;

	always_comb begin
		n_full = (32'(count) > MAX_WAYPOINTS) ? MAX_WAYPOINTS : 32'(count);
		n_w = CW'(n_full);
		dx_w = $signed({rd_s1[63], rd_s1[63:32]}) - $signed({px_q[31], px_q});
		dy_w = $signed({rd_s1[31], rd_s1[31:0]}) - $signed({py_q[31], py_q});
		mx = dx_s2[32] ? 33'(-dx_s2) : 33'(dx_s2);
		my = dy_s2[32] ? 33'(-dy_s2) : 33'(dy_s2);
		sqx = mx * mx;
		sqy = my * my;
		sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		d2sat = (sum[65:64] != 2'b00) ? '1 : sum[63:0];
		hit = (state_q == SC_RUN) && v_s3 && (d2sat >= {18'b0, h2_q});
		issue = (state_q == SC_RUN) && (issued_q != n_q) && !hit;
		drained = !v_s1 && !v_s2 && !v_s3;
	end

	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_slot) < MAX_WAYPOINTS)) begin
			mem[AW'(wr_slot)] <= {wr_east, wr_north};
		end
		rd_s1 <= mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			tracked_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == SC_RUN);
			v_s3 <= v_s2 && (state_q == SC_RUN);
			unique case (state_q)
				SC_IDLE: begin
					if (start) begin
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						v_s3 <= 1'b0;
						if (n_w == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= SC_MOD;
						end
					end
				end
				SC_MOD: begin
					if (addr_q < n_q) begin
						state_q <= SC_RUN;
					end
				end
				SC_RUN: begin
					if (hit) begin
						tracked_q <= AW'(idx_s3);
						done_q <= 1'b1;
						state_q <= SC_IDLE;
					end else if (issued_q == n_q && drained) begin
						done_q <= 1'b1;
						state_q <= SC_IDLE;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && start) begin
			n_q <= n_w;
			addr_q <= CW'(tracked_q);
			issued_q <= '0;
			px_q <= pose_east;
			py_q <= pose_north;
			h2_q <= 46'(horizon) * 46'(horizon);
			goal_q.found <= 1'b0;
		end else if (state_q == SC_MOD) begin
			if (addr_q >= n_q) begin
				addr_q <= addr_q - n_q;
			end
		end else if (issue) begin
			addr_q <= (addr_q == n_q - CW'(1)) ? '0 : addr_q + CW'(1);
			issued_q <= issued_q + CW'(1);
		end
		if (hit) begin
			goal_q <= '{found: 1'b1, dx: dx_s3, dy: dy_s3, d2: d2sat};
		end
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		dx_s2 <= dx_w;
		dy_s2 <= dy_w;
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		sqx_s3 <= sqx[64:0];
		sqy_s3 <= sqy[64:0];
	end

	assign done = done_q;
	assign goal = goal_q;
	assign tracked = tracked_q;
endmodule
`default_nettype wire

### hdl/ppst_steer.sv
`default_nettype none
module ppst_steer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ppst_pkg::goal_t       goal,
	input  ppst_pkg::quat_t       quat,
	input  ppst_pkg::speed_cfg_t  spd,
	output logic                  done,
	output logic signed [11:0]    steer,
	output logic [15:0]           speed
);
	import ppst_pkg::*;

	localparam logic [15:0] TwoWheelbase = 16'd43254;
	localparam logic [10:0] SteerClamp = 11'd1638;
	localparam logic [63:0] NearSq = 64'd4295;
	localparam logic [29:0] Recip3 = 30'd715827883;
	localparam logic [29:0] Recip5 = 30'd429496730;
	localparam logic [29:0] Recip7 = 30'd306783379;

	typedef enum logic [19:0] {
		SP_IDLE   = 20'h00001,
		SP_QPROD  = 20'h00002,
		SP_QCOEF  = 20'h00004,
		SP_YA     = 20'h00008,
		SP_YB     = 20'h00010,
		SP_YDIV   = 20'h00020,
		SP_NUM    = 20'h00040,
		SP_RDIV   = 20'h00080,
		SP_P2     = 20'h00100,
		SP_P3     = 20'h00200,
		SP_P5     = 20'h00400,
		SP_P7     = 20'h00800,
		SP_D3     = 20'h01000,
		SP_D5     = 20'h02000,
		SP_D7     = 20'h04000,
		SP_ATAN   = 20'h08000,
		SP_FSTART = 20'h10000,
		SP_FDIV   = 20'h20000,
		SP_SQRT   = 20'h40000,
		SP_SPD    = 20'h80000
	} sp_state_t;

	sp_state_t state_q;
	goal_t goal_q;
	quat_t q_q;
	logic [30:0] ii_q, jj_q, kk_q, ww_q;
	logic signed [31:0] ij_q, wk_q;
	logic [32:0] n_q;
	logic signed [33:0] a_q, b_q;
	logic [63:0] pa_q, num_q;
	logic neg_q, done_q;
	logic [27:0] r_q, r2_q, r3_q, r5_q, r7_q, t3_q, t5_q, t7_q;
	logic [10:0] s_q;
	logic [33:0] v_q, res_q, sqb_q;
	logic signed [11:0] steer_q;
	logic [15:0] speed_q;

	div_req_t div_req;
	logic div_done;
	logic [63:0] quot;

	logic signed [31:0] qi_w, qj_w, qk_w, qw_w;
	logic signed [63:0] y_w;
	logic [63:0] magy;
	logic [29:0] m_a, m_b;
	logic [59:0] prod;
	logic [29:0] at_w;
	logic [12:0] sr_w;
	logic [13:0] lim_w;
	logic [33:0] trial;
	logic [15:0] diff;
	logic [33:0] step_full;
	logic [16:0] step_w;
	logic [79:0] num_w;

	ppst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		qi_w = 32'(q_q.qi);
		qj_w = 32'(q_q.qj);
		qk_w = 32'(q_q.qk);
		qw_w = 32'(q_q.qw);
		y_w = $signed(pa_q) + 64'(b_q) * 64'(goal_q.dy);
		magy = y_w[63] ? 64'(-y_w) : 64'(y_w);
		num_w = quot * 80'(TwoWheelbase);
		lim_w = (spd.lim == '0) ? 14'd1 : spd.lim;
		m_a = '0;
		m_b = '0;
		case (state_q)
			SP_P2: begin m_a = 30'(r_q); m_b = 30'(r_q); end
			SP_P3: begin m_a = 30'(r_q); m_b = 30'(r2_q); end
			SP_P5: begin m_a = 30'(r3_q); m_b = 30'(r2_q); end
			SP_P7: begin m_a = 30'(r5_q); m_b = 30'(r2_q); end
			SP_D3: begin m_a = 30'(r3_q); m_b = Recip3; end
			SP_D5: begin m_a = 30'(r5_q); m_b = Recip5; end
			SP_D7: begin m_a = 30'(r7_q); m_b = Recip7; end
			default: ;
		endcase
		prod = m_a * m_b;
		at_w = 30'(r_q) - 30'(t3_q) + 30'(t5_q) - 30'(t7_q);
		sr_w = 13'((at_w + 30'd65536) >> 17);
		trial = res_q + sqb_q;
		diff = (spd.top >= spd.bottom) ? spd.top - spd.bottom : spd.bottom - spd.top;
		step_full = 34'(diff) * 34'(res_q[16:0]) + 34'd32768;
		step_w = step_full[32:16];

		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.rem_init = '0;
		div_req.divisor = '0;
		div_req.steps = 7'd64;
		if (state_q == SP_YB) begin
			div_req.start = 1'b1;
			div_req.dividend = magy;
			div_req.divisor = 64'(n_q);
		end else if (state_q == SP_NUM && num_q != '0 && num_q < goal_q.d2) begin
			div_req.start = 1'b1;
			div_req.rem_init = num_q;
			div_req.divisor = goal_q.d2;
			div_req.steps = 7'd30;
		end else if (state_q == SP_FSTART && 14'(s_q) < lim_w) begin
			div_req.start = 1'b1;
			div_req.dividend = 64'({lim_w - 14'(s_q), 16'b0});
			div_req.divisor = 64'(lim_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SP_IDLE: begin
					if (start) begin
						if (!goal.found || goal.d2 < NearSq || goal.d2[63:62] != 2'b00) begin
							state_q <= SP_FSTART;
						end else begin
							state_q <= SP_QPROD;
						end
					end
				end
				SP_QPROD: state_q <= SP_QCOEF;
				SP_QCOEF: state_q <= SP_YA;
				SP_YA:    state_q <= SP_YB;
				SP_YB:    state_q <= SP_YDIV;
				SP_YDIV: begin
					if (div_done) state_q <= SP_NUM;
				end
				SP_NUM: begin
					if (num_q == '0 || num_q >= goal_q.d2) begin
						state_q <= SP_FSTART;
					end else begin
						state_q <= SP_RDIV;
					end
				end
				SP_RDIV: begin
					if (div_done) begin
						state_q <= (quot[29:28] != 2'b00) ? SP_FSTART : SP_P2;
					end
				end
				SP_P2:   state_q <= SP_P3;
				SP_P3:   state_q <= SP_P5;
				SP_P5:   state_q <= SP_P7;
				SP_P7:   state_q <= SP_D3;
				SP_D3:   state_q <= SP_D5;
				SP_D5:   state_q <= SP_D7;
				SP_D7:   state_q <= SP_ATAN;
				SP_ATAN: state_q <= SP_FSTART;
				SP_FSTART: begin
					state_q <= (14'(s_q) < lim_w) ? SP_FDIV : SP_SQRT;
				end
				SP_FDIV: begin
					if (div_done) state_q <= SP_SQRT;
				end
				SP_SQRT: begin
					if (sqb_q[0]) state_q <= SP_SPD;
				end
				SP_SPD: begin
					done_q <= 1'b1;
					state_q <= SP_IDLE;
				end
				default: state_q <= SP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SP_IDLE: begin
				goal_q <= goal;
				q_q <= quat;
				s_q <= '0;
				neg_q <= 1'b0;
			end
			SP_QPROD: begin
				ii_q <= 31'(qi_w * qi_w);
				jj_q <= 31'(qj_w * qj_w);
				kk_q <= 31'(qk_w * qk_w);
				ww_q <= 31'(qw_w * qw_w);
				ij_q <= qi_w * qj_w;
				wk_q <= qw_w * qk_w;
			end
			SP_QCOEF: begin
				if ((33'(ii_q) + 33'(jj_q) + 33'(kk_q) + 33'(ww_q)) == '0) begin
					a_q <= '0;
					b_q <= 34'sd1;
					n_q <= 33'd1;
				end else begin
					a_q <= (34'(ij_q) - 34'(wk_q)) <<< 1;
					b_q <= $signed(34'(ww_q) + 34'(jj_q) - 34'(ii_q) - 34'(kk_q));
					n_q <= 33'(ii_q) + 33'(jj_q) + 33'(kk_q) + 33'(ww_q);
				end
			end
			SP_YA: pa_q <= 64'(64'(a_q) * 64'(goal_q.dx));
			SP_YB: neg_q <= y_w[63];
			SP_YDIV: begin
				if (div_done) num_q <= num_w[63:0];
			end
			SP_NUM: begin
				if (num_q == '0) begin
					neg_q <= 1'b0;
				end else if (num_q >= goal_q.d2) begin
					s_q <= SteerClamp;
				end
			end
			SP_RDIV: begin
				if (div_done) begin
					r_q <= quot[27:0];
					if (quot[29:28] != 2'b00) s_q <= SteerClamp;
				end
			end
			SP_P2: r2_q <= prod[57:30];
			SP_P3: r3_q <= prod[57:30];
			SP_P5: r5_q <= prod[57:30];
			SP_P7: r7_q <= prod[57:30];
			SP_D3: t3_q <= prod[58:31];
			SP_D5: t5_q <= prod[58:31];
			SP_D7: t7_q <= prod[58:31];
			SP_ATAN: s_q <= (sr_w > 13'(SteerClamp)) ? SteerClamp : 11'(sr_w);
			SP_FSTART: begin
				v_q <= '0;
				res_q <= '0;
				sqb_q <= 34'h1_0000_0000;
			end
			SP_FDIV: begin
				if (div_done) v_q <= {1'b0, quot[16:0], 16'b0};
			end
			SP_SQRT: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					res_q <= (res_q >> 1) + sqb_q;
				end else begin
					res_q <= res_q >> 1;
				end
				sqb_q <= sqb_q >> 2;
			end
			SP_SPD: begin
				steer_q <= neg_q ? -$signed(12'(s_q)) : $signed(12'(s_q));
				speed_q <= (spd.top >= spd.bottom) ? 16'(17'(spd.bottom) + step_w)
					: 16'(17'(spd.bottom) - step_w);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign steer = steer_q;
	assign speed = speed_q;
endmodule
`default_nettype wire
